### rtl/core/byte_ring_buffer_with_overwrite_unit_macros.svh
// Assertion macros for the byte ring buffer unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BYTE_RING_BUFFER_WITH_OVERWRITE_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_OVERWRITE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BRB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("brb assertion failed");
`define BRB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("brb assertion failed");
`else
`define BRB_ASSERT(lbl, clk, rst, prop)
`define BRB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/brb_pkg.sv
// Shared types and constants for the byte ring buffer unit.
// No dependencies; used by brb_merge and the top-level unit in rtl/core.
package brb_pkg;
   localparam int DEPTH_DEF       = 4096;
   localparam int LANES_DEF       = 8;
   localparam int PEEK_WORD_BYTES = 4;
   localparam int CNT_W           = 4;
   localparam int RING_POS_W      = 12;
   localparam int LANE_SEL_W      = 3;
   localparam int REQ_DATA_W      = 216;
   localparam int RSP_DATA_W      = 208;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_PEEK32 = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC1,
      S_CALC2,
      S_ISSUE,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [LANE_SEL_W-1:0]   shift;
      logic [CNT_W-1:0]        count;
   } merge_ctl_type;
endpackage

### rtl/core/brb_lane.sv
// One byte lane of the ring store: a bank of DEPTH/LANES bytes.
// One write and one registered read per cycle; no package dependencies.
module brb_lane #(
   parameter int ROW_W = 9
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row,
   output logic [7:0]       rd_data
);
   logic [7:0] mem [2**ROW_W];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/brb_merge.sv
// Merge stage: rotate lane read data into stream order and shape the result.
// Depends on brb_pkg.
module brb_merge #(
   parameter int LANES = brb_pkg::LANES_DEF
) (
   input  logic [8*LANES-1:0]   lane_data,
   input  brb_pkg::merge_ctl_type ctl,
   output logic [63:0]          read_bytes
);
   localparam int LB = $clog2(LANES);

   logic [7:0]  ordered [LANES];
   logic [63:0] pop_word;
   logic [31:0] be_word;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         ordered[j] = lane_data[8*(LB'(ctl.shift[LB-1:0] + LB'(j))) +: 8];
      end
      pop_word = '0;
      for (int j = 0; j < LANES; j++) begin
         if (brb_pkg::CNT_W'(j) < ctl.count) begin
            pop_word[8*j +: 8] = ordered[j];
         end
      end
      be_word = {ordered[0], ordered[1], ordered[2], ordered[3]};
      case (ctl.cmd)
         brb_pkg::CMD_POP: begin
            read_bytes = pop_word;
         end
         brb_pkg::CMD_PEEK32: begin
            read_bytes = (ctl.count != '0) ? {32'd0, be_word} : 64'd0;
         end
         default: begin
            read_bytes = 64'd0;
         end
      endcase
   end
endmodule

### rtl/core/byte_ring_buffer_with_overwrite_unit.sv
// Byte ring buffer with overwrite: one command per beat, one result beat each.
// An item passes from acceptance to the result beat through two compare/subtract
// stages on the 64-bit counters, one stage that sizes the access and drives the
// banked memory and one merge stage; the next beat is taken in the cycle after the
// result beat has been delivered, so the unit holds one item at a time.
// The store is LANES byte banks (DEPTH and LANES powers of two), each written and
// read once per access, so up to LANES bytes move in a single memory cycle.
// Depends on brb_pkg, brb_lane, brb_merge and the macros header.
`include "byte_ring_buffer_with_overwrite_unit_macros.svh"
module byte_ring_buffer_with_overwrite_unit #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF,
   parameter int LANES = brb_pkg::LANES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // byte_count[3:0], push_bytes[67:4], reader_position[131:68],
   // stream_offset[195:132], relative_skip[208:196], zero pad
   input  logic [brb_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0], force_req[2]
   input  logic [2:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // done_count[3:0], read_bytes[67:4], next_offset[131:68],
   // lost_bytes[195:132], ring_position[207:196]
   output logic [brb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   localparam int AW    = $clog2(DEPTH);
   localparam int LB    = $clog2(LANES);
   localparam int ROW_W = (AW > LB) ? AW - LB : 1;
   localparam int CW    = brb_pkg::CNT_W;
   localparam logic [63:0] DEPTH64 = 64'(DEPTH);
   localparam logic [CW-1:0] LANES_C = CW'(LANES);
   localparam int LANE_SHW = brb_pkg::LANE_SEL_W;

   brb_pkg::state_type state_ff, state_in;

   brb_pkg::cmd_type cmd_ff;
   logic             force_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [63:0]      push_ff, rpos_ff, soff_ff;
   logic [12:0]      skip_ff;
   logic [63:0]      wc_ff, wc_in;

   logic [63:0] used_ff, wcmd_ff, start_ff, diff_ff;
   logic        rpos_le_ff, wcgt_ff, have_ff, soff_le_ff;
   logic        push_ok_ff, start_le_ff, p32_ok_ff;
   logic [63:0] off_ff, lost_ff;
   logic [CW-1:0] n_ff, done_ff;
   logic [AW-1:0] pos_ff;
   logic [LANE_SHW-1:0] shift_ff;

   logic [brb_pkg::RSP_DATA_W-1:0] rsp_ff;

   // issue-stage signals
   logic [63:0]   base;
   logic [CW-1:0] n_in, done_in;
   logic [63:0]   avail;
   logic [AW:0]   room;
   logic          push_go;
   logic [8*LANES-1:0] lane_rd;
   logic [63:0]   merged;
   brb_pkg::merge_ctl_type mctl;
   logic [63:0]   next_off;
   logic [CW-1:0] done_out;
   logic          behind;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brb_pkg::S_IDLE:  if (req_tvalid) state_in = brb_pkg::S_CALC1;
         brb_pkg::S_CALC1: state_in = brb_pkg::S_CALC2;
         brb_pkg::S_CALC2: state_in = brb_pkg::S_ISSUE;
         brb_pkg::S_ISSUE: state_in = brb_pkg::S_READ;
         brb_pkg::S_READ:  state_in = brb_pkg::S_DONE;
         brb_pkg::S_DONE:  if (rsp_tready) state_in = brb_pkg::S_IDLE;
         default:          state_in = brb_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == brb_pkg::S_IDLE);
      rsp_tvalid = (state_ff == brb_pkg::S_DONE);
   end
   assign rsp_tdata = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brb_pkg::S_IDLE;
         wc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wc_ff    <= wc_in;
      end
   end

   assign count_in = (req_tdata[3:0] > LANES_C) ? LANES_C : req_tdata[3:0];

   // capture, compare stages, issue registers and result beat register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff   <= brb_pkg::cmd_type'(req_tuser[1:0]);
         force_ff <= req_tuser[2];
         count_ff <= count_in;
         push_ff  <= req_tdata[67:4];
         rpos_ff  <= req_tdata[131:68];
         soff_ff  <= req_tdata[195:132];
         skip_ff  <= req_tdata[208:196];
      end
      if (state_ff == brb_pkg::S_CALC1) begin
         used_ff    <= wc_ff - rpos_ff;
         rpos_le_ff <= rpos_ff <= wc_ff;
         wcmd_ff    <= wc_ff - DEPTH64;
         wcgt_ff    <= wc_ff > DEPTH64;
         have_ff    <= wc_ff > soff_ff;
         start_ff   <= rpos_ff + 64'(skip_ff);
         diff_ff    <= wc_ff - soff_ff;
         soff_le_ff <= soff_ff <= wc_ff;
      end
      if (state_ff == brb_pkg::S_CALC2) begin
         push_ok_ff  <= (count_ff != '0) && (force_ff || (rpos_le_ff &&
                        used_ff <= DEPTH64 && (used_ff + 64'(count_ff)) <= DEPTH64));
         off_ff      <= behind ? wcmd_ff : soff_ff;
         lost_ff     <= behind ? (wcmd_ff - soff_ff) : 64'd0;
         start_le_ff <= start_ff <= wc_ff;
         p32_ok_ff   <= soff_le_ff && (diff_ff >= 64'(brb_pkg::PEEK_WORD_BYTES));
      end
      if (state_ff == brb_pkg::S_ISSUE) begin
         n_ff     <= n_in;
         done_ff  <= done_in;
         pos_ff   <= start_ff[AW-1:0];
         shift_ff <= LANE_SHW'(base[LB-1:0]);
      end
      if (state_ff == brb_pkg::S_READ) begin
         rsp_ff <= {(cmd_ff == brb_pkg::CMD_PEEK && start_le_ff)
                      ? brb_pkg::RING_POS_W'(pos_ff) : {brb_pkg::RING_POS_W{1'b0}},
                    (cmd_ff == brb_pkg::CMD_POP) ? lost_ff : 64'd0,
                    next_off, merged, done_out};
      end
   end

   assign behind = wcgt_ff && (soff_ff < wcmd_ff);

   // issue stage: counts, base address and write counter update
   always_comb begin
      avail   = wc_ff - off_ff;
      room    = (AW+1)'(DEPTH) - {1'b0, start_ff[AW-1:0]};
      base    = 64'd0;
      n_in    = '0;
      done_in = '0;
      push_go = 1'b0;
      wc_in   = wc_ff;
      case (cmd_ff)
         brb_pkg::CMD_PUSH: begin
            base = wc_ff;
            if (push_ok_ff) begin
               n_in    = count_ff;
               done_in = count_ff;
               push_go = (state_ff == brb_pkg::S_ISSUE);
               if (push_go) wc_in = wc_ff + 64'(count_ff);
            end
         end
         brb_pkg::CMD_POP: begin
            base = off_ff;
            if (have_ff) begin
               n_in    = (avail < 64'(count_ff)) ? avail[CW-1:0] : count_ff;
               done_in = n_in;
            end
         end
         brb_pkg::CMD_PEEK: begin
            if (start_le_ff) begin
               done_in = (room < (AW+1)'(count_ff)) ? CW'(room) : count_ff;
            end
         end
         brb_pkg::CMD_PEEK32: begin
            base = soff_ff;
            n_in = p32_ok_ff ? CW'(brb_pkg::PEEK_WORD_BYTES) : '0;
         end
         default: begin
            base = 64'd0;
         end
      endcase
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [LB-1:0]    j;
      logic [AW-1:0]    addr;
      logic [ROW_W-1:0] row;
      logic [7:0]       wbyte;

      always_comb begin
         j     = LB'(l) - base[LB-1:0];
         addr  = base[AW-1:0] + AW'(j);
         row   = ROW_W'(addr >> LB);
         wbyte = push_ff[8*j +: 8];
      end

      brb_lane #(.ROW_W(ROW_W)) u_lane (
         .clock   (clock),
         .wr_en   (push_go && (CW'(j) < n_in)),
         .wr_row  (row),
         .wr_data (wbyte),
         .rd_en   (state_ff == brb_pkg::S_ISSUE),
         .rd_row  (row),
         .rd_data (lane_rd[8*l +: 8])
      );
   end

   assign mctl = '{cmd: cmd_ff, shift: shift_ff, count: n_ff};

   brb_merge #(.LANES(LANES)) u_merge (
      .lane_data  (lane_rd),
      .ctl        (mctl),
      .read_bytes (merged)
   );

   always_comb begin
      next_off = (cmd_ff == brb_pkg::CMD_POP) ? off_ff + 64'(n_ff) : 64'd0;
      done_out = (cmd_ff == brb_pkg::CMD_PEEK32) ? '0 : done_ff;
   end

   `BRB_ASSERT(a_one_side, clock, reset, rsp_tvalid |-> !req_tready)
   `BRB_ASSERT(a_wc_only_push, clock, reset,
      (state_ff != brb_pkg::S_ISSUE) |=> (wc_ff == $past(wc_ff)))
   `BRB_ASSERT(a_done_bound, clock, reset, rsp_tvalid |-> (rsp_tdata[3:0] <= LANES_C))
   `BRB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == brb_pkg::S_IDLE))
endmodule

### tb/tb_byte_ring_buffer_with_overwrite_unit.sv
// Testbench for the byte ring buffer with overwrite: drives push, pop, peek and
// peek32 commands as request beats and checks every response against a local model.
// Depends on brb_pkg and byte_ring_buffer_with_overwrite_unit.
module tb_byte_ring_buffer_with_overwrite_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = brb_pkg::DEPTH_DEF;
   localparam int LANE_CNT   = brb_pkg::LANES_DEF;
   localparam logic [63:0] RING_DEPTH64 = 64'(RING_DEPTH);

   typedef struct packed {
      logic [12:0] relative_skip;
      logic [63:0] stream_offset;
      logic [63:0] reader_position;
      logic [63:0] push_bytes;
      logic [3:0]  byte_count;
   } req_fields_type;

   typedef struct packed {
      logic [11:0] ring_position;
      logic [63:0] lost_bytes;
      logic [63:0] next_offset;
      logic [63:0] read_bytes;
      logic [3:0]  done_count;
   } rsp_fields_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [brb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [brb_pkg::RSP_DATA_W-1:0] rsp_tdata;

   byte_ring_buffer_with_overwrite_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [63:0]    wr_count;
   logic [7:0]     ring_bytes [RING_DEPTH];
   rsp_fields_type expected_rsps [$];
   int             mismatches = 0;
   bit             calm = 1'b0;
   bit             hold_rsp = 1'b0;

   function automatic int ring_idx(logic [63:0] x);
      return int'(x % RING_DEPTH64);
   endfunction

   function automatic rsp_fields_type predict_rsp(brb_pkg::cmd_type cmd, bit frc,
                                                  req_fields_type r);
      rsp_fields_type o;
      logic [63:0] cnt, used, room, off, start, pos;
      o = '0;
      cnt = (r.byte_count > 4'(LANE_CNT)) ? 64'(LANE_CNT) : 64'(r.byte_count);
      case (cmd)
         brb_pkg::CMD_PUSH: begin
            used = wr_count - r.reader_position;
            room = '0;
            if (r.reader_position <= wr_count && used <= RING_DEPTH64)
               room = RING_DEPTH64 - used;
            if (cnt > 0 && (frc || cnt <= room)) begin
               for (int i = 0; i < int'(cnt); i++)
                  ring_bytes[ring_idx(wr_count + 64'(i))] = r.push_bytes[8*i +: 8];
               wr_count += cnt;
               o.done_count = 4'(cnt);
            end
         end
         brb_pkg::CMD_POP: begin
            off = r.stream_offset;
            if (wr_count > off) begin
               if (wr_count > RING_DEPTH64 && off < wr_count - RING_DEPTH64) begin
                  o.lost_bytes = wr_count - RING_DEPTH64 - off;
                  off = wr_count - RING_DEPTH64;
               end
               if (cnt > wr_count - off) cnt = wr_count - off;
               for (int i = 0; i < int'(cnt); i++)
                  o.read_bytes[8*i +: 8] = ring_bytes[ring_idx(off + 64'(i))];
               off += cnt;
               o.done_count = 4'(cnt);
            end
            o.next_offset = off;
         end
         brb_pkg::CMD_PEEK: begin
            start = r.reader_position + 64'(r.relative_skip);
            if (start <= wr_count) begin
               pos = start % RING_DEPTH64;
               o.done_count = 4'((cnt < RING_DEPTH64 - pos) ? cnt : RING_DEPTH64 - pos);
               o.ring_position = pos[11:0];
            end
         end
         default: begin
            off = r.stream_offset;
            if (off <= wr_count && wr_count - off >= 64'(brb_pkg::PEEK_WORD_BYTES))
               for (int i = 0; i < 4; i++)
                  o.read_bytes[31-8*i -: 8] = ring_bytes[ring_idx(off + 64'(i))];
         end
      endcase
      return o;
   endfunction

   task automatic send_cmd(brb_pkg::cmd_type cmd, bit frc, req_fields_type r);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= brb_pkg::REQ_DATA_W'(r);
      req_tuser  <= {frc, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsps.push_back(predict_rsp(cmd, frc, r));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      rsp_fields_type got, exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_fields_type'(rsp_tdata);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (got !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp done=%0d rd=%h nxt=%h lost=%h pos=%h",
                           exp_rsp.done_count, exp_rsp.read_bytes, exp_rsp.next_offset,
                           exp_rsp.lost_bytes, exp_rsp.ring_position);
                  $display("          got done=%0d rd=%h nxt=%h lost=%h pos=%h",
                           got.done_count, got.read_bytes, got.next_offset,
                           got.lost_bytes, got.ring_position);
               end
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_fields_type make_req(logic [3:0] cnt, logic [63:0] rpos,
                                                logic [63:0] soff, logic [12:0] skip);
      req_fields_type r;
      r.byte_count = cnt;
      r.push_bytes = rand64();
      r.reader_position = rpos;
      r.stream_offset = soff;
      r.relative_skip = skip;
      return r;
   endfunction

   // Offsets mostly land on written bytes; others lie past the write counter or at random and hit the short paths.
   function automatic logic [63:0] safe_offset();
      logic [63:0] span;
      span = (wr_count < RING_DEPTH64) ? wr_count : RING_DEPTH64;
      case ($urandom_range(5))
         0: return wr_count + 64'($urandom_range(16));
         1: return rand64();
         2: return (wr_count > RING_DEPTH64) ? 64'($urandom_range(RING_DEPTH)) : wr_count;
         default: return wr_count - 64'($urandom_range(32'(span)));
      endcase
   endfunction

   task automatic test_directed();
      send_cmd(brb_pkg::CMD_POP, 0, make_req(8, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PEEK32, 0, make_req(4, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(8, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(8, 0, 0, 1));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(0, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(15, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 1, make_req(3, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(8, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(8, 100, 0, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(0, 0, 0, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(15, 0, 0, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(8, 0, 5, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(8, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
      send_cmd(brb_pkg::CMD_PEEK32, 0, make_req(0, 0, 0, 0));
      send_cmd(brb_pkg::CMD_PEEK32, 0, make_req(0, 0, wr_count - 64'd3, 0));
      send_cmd(brb_pkg::CMD_PEEK32, 0, make_req(0, 0, wr_count + 64'd1, 0));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(15, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(8, 0, 0, 13'h1FFF));
   endtask

   task automatic test_wrap_and_snap();
      // fill just past the ring with forced pushes, then read from far behind
      while (wr_count <= RING_DEPTH64 + 64'd8)
         send_cmd(brb_pkg::CMD_PUSH, 1, make_req(8, 0, 0, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(8, 0, 0, 0));
      send_cmd(brb_pkg::CMD_POP, 0, make_req(8, 0, wr_count - RING_DEPTH64 - 64'd1, 0));
      send_cmd(brb_pkg::CMD_PEEK32, 0, make_req(0, 0, wr_count - RING_DEPTH64 - 64'd2, 0));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(8, wr_count - 64'd3, 0, 0));
      send_cmd(brb_pkg::CMD_PEEK, 0, make_req(8, RING_DEPTH64 - 64'd3, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(8, wr_count - RING_DEPTH64 - 64'd1, 0, 0));
      send_cmd(brb_pkg::CMD_PUSH, 0, make_req(8, wr_count - RING_DEPTH64 + 64'd8, 0, 0));
   endtask

   task automatic test_random(int n);
      brb_pkg::cmd_type cmd;
      logic [63:0] rpos;
      logic [12:0] skip;
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 4 && i < n / 4 + n / 2);
         cmd = brb_pkg::cmd_type'(2'($urandom_range(3)));
         rpos = ($urandom_range(9) == 0) ? rand64() :
                wr_count - 64'($urandom_range(RING_DEPTH + 8));
         skip = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(24));
         send_cmd(cmd, 1'($urandom_range(1)),
                  make_req(4'($urandom_range(15)), rpos, safe_offset(), skip));
      end
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_cmd(brb_pkg::CMD_PUSH, 1, make_req(8, 0, 0, 0));
      join
   endtask

   initial begin
      int guard;
      wr_count = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_wrap_and_snap();
      test_random(60);
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_rsps.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end
endmodule
